// File: rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam int unsigned OPCODE_BITS = 3;
    localparam int unsigned FIELD_BITS  = 32;
    localparam int unsigned DEN_BITS    = 31;
    localparam int unsigned ORDER_BITS  = 2;
    localparam int unsigned STATUS_BITS = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_RED = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [ORDER_BITS-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

    // request from sequencer to the shared divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/rau_mul.sv
`default_nettype none
// Shift-and-add multiplier, one bit of the multiplier per cycle.
module rau_mul #(
    parameter int unsigned W = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [W-1:0]   op_a,
    input  wire logic [W-1:0]   op_b,
    output logic                done,
    output logic [2*W-1:0]      product
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                mcand_reg  <= {{W{1'b0}}, op_a};
                mplier_reg <= op_b;
            end else if (busy_reg) begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

// File: rtl/core/rau_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rau_div #(
    parameter int unsigned W = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rau_pkg::div_ctl_t   ctl,
    input  wire logic [2*W-1:0]      dividend,
    input  wire logic [2*W-1:0]      divisor,
    output rau_pkg::div_sts_t        sts,
    output logic [2*W-1:0]           quotient,
    output logic [2*W-1:0]           remainder
);
    import rau_pkg::*;

    localparam int unsigned DW = 2 * W;
    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg, q_reg[DW-1]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (!trial[DW]) begin
                    r_reg <= trial[DW-1:0];
                    q_reg <= {q_reg[DW-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[DW-2:0], q_reg[DW-1]};
                    q_reg <= {q_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

// File: rtl/core/rational_arithmetic_unit.sv
`default_nettype none
// Sequence: four multiplies, then Euclid remainder steps on the shared divider until the
// divisor reaches zero, then two exact divisions of numerator and denominator by the gcd.
// A zero denominator at input goes straight to the result; compare ends after the multiplies.
// Throughput: one item at a time; s_ready is low from accept until the result is taken.
// Reset: aresetn synchronous active low clears the sequencer and output valid.
module rational_arithmetic_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rau_pkg::OPCODE_BITS-1:0] s_opcode,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]  s_a_num,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]  s_a_den,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]  s_b_num,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]  s_b_den,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rau_pkg::FIELD_BITS-1:0]       m_res_num,
    output logic [rau_pkg::DEN_BITS-1:0]         m_res_den,
    output logic [rau_pkg::ORDER_BITS-1:0]       m_order,
    output logic [rau_pkg::STATUS_BITS-1:0]      m_status
);
    import rau_pkg::*;

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned DW = 2 * W;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_GCDW,
        S_DN, S_DNW, S_DD, S_DDW, S_CHK, S_OUT
    } state_t;

    state_t         state_reg;
    opcode_t        op_reg;
    logic           an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic [DW-1:0]  p0_reg, p1_reg, p2_reg;
    logic [DW-1:0]  num_reg, den_reg, gx_reg, gy_reg, g_reg;
    logic           neg_reg;
    logic [FIELD_BITS-1:0]  res_num_reg;
    logic [DEN_BITS-1:0]    res_den_reg;
    logic [ORDER_BITS-1:0]  order_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic           m_valid_reg;

    // sign/magnitude of low W bits
    function automatic logic [W:0] sm(input logic [FIELD_BITS-1:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        return v[W-1] ? {1'b1, W'(-v)} : {1'b0, v};
    endfunction

    logic [W:0] an_sm, ad_sm, bn_sm, bd_sm;
    assign an_sm = sm(s_a_num);
    assign ad_sm = sm(s_a_den);
    assign bn_sm = sm(s_b_num);
    assign bd_sm = sm(s_b_den);

    // multiplier
    logic          mul_start, mul_done;
    logic [W-1:0]  mul_a, mul_b;
    logic [DW-1:0] mul_p;

    rau_mul #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
    );

    // divider
    div_ctl_t      div_ctl;
    div_sts_t      div_sts;
    logic [DW-1:0] div_n, div_d, div_q, div_r;

    rau_div #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(div_ctl),
        .dividend(div_n), .divisor(div_d), .sts(div_sts),
        .quotient(div_q), .remainder(div_r)
    );

    always_comb begin
        mul_start = 1'b0;
        mul_a = an_reg;
        mul_b = bd_reg;
        div_ctl.start = 1'b0;
        div_n = gx_reg;
        div_d = gy_reg;
        unique case (state_reg)
            S_M0: begin mul_start = 1'b1; mul_a = an_reg; mul_b = bd_reg; end
            S_M1: begin mul_start = mul_done; mul_a = ad_reg; mul_b = bn_reg; end
            S_M2: begin mul_start = mul_done; mul_a = ad_reg; mul_b = bd_reg; end
            S_M3: begin mul_start = mul_done; mul_a = an_reg; mul_b = bn_reg; end
            // no remainder step once the divisor has reached zero
            S_GCD: begin div_ctl.start = (gy_reg != '0); end
            S_DN: begin div_ctl.start = 1'b1; div_n = num_reg; div_d = g_reg; end
            S_DD: begin div_ctl.start = 1'b1; div_n = den_reg; div_d = g_reg; end
            default: ;
        endcase
    end

    // signed add of two sign/magnitude values
    logic          t_neg, u_neg, sum_neg;
    logic [DW-1:0] sum_mag;
    always_comb begin
        t_neg = an_neg_reg ^ bd_neg_reg;
        u_neg = (ad_neg_reg ^ bn_neg_reg) ^ (op_reg == OP_SUB);
        if (t_neg == u_neg) begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = t_neg;
        end else if (p0_reg >= p1_reg) begin
            sum_mag = p0_reg - p1_reg;
            sum_neg = t_neg;
        end else begin
            sum_mag = p1_reg - p0_reg;
            sum_neg = u_neg;
        end
    end

    // compare: l = an*bd sign an^ad, r = bn*ad sign bn^bd
    logic [ORDER_BITS-1:0] cmp_ord;
    logic l_neg, r_neg;
    always_comb begin
        l_neg = (p0_reg != '0) && (an_neg_reg ^ ad_neg_reg);
        r_neg = (p1_reg != '0) && (bn_neg_reg ^ bd_neg_reg);
        if (l_neg != r_neg) begin
            cmp_ord = l_neg ? ORD_LESS : ORD_GREATER;
        end else if (p0_reg == p1_reg) begin
            cmp_ord = ORD_EQUAL;
        end else if (l_neg) begin
            cmp_ord = (p0_reg > p1_reg) ? ORD_LESS : ORD_GREATER;
        end else begin
            cmp_ord = (p0_reg > p1_reg) ? ORD_GREATER : ORD_LESS;
        end
    end

    localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);
    logic ovf;
    assign ovf = (den_reg > LIM - 1'b1) || (neg_reg ? (num_reg > LIM) : (num_reg > LIM - 1'b1));

    logic [W-1:0] n_out;
    assign n_out = neg_reg ? W'(-num_reg[W-1:0]) : num_reg[W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= (s_opcode > OP_RED) ? OP_RED : opcode_t'(s_opcode);
                        an_neg_reg <= an_sm[W]; an_reg <= an_sm[W-1:0];
                        ad_neg_reg <= ad_sm[W]; ad_reg <= ad_sm[W-1:0];
                        bn_neg_reg <= bn_sm[W]; bn_reg <= bn_sm[W-1:0];
                        bd_neg_reg <= bd_sm[W]; bd_reg <= bd_sm[W-1:0];
                        order_reg  <= ORD_LESS;
                        res_num_reg <= '0;
                        res_den_reg <= '0;
                        if (ad_sm[W-1:0] == '0 ||
                            (s_opcode <= OP_CMP && bd_sm[W-1:0] == '0)) begin
                            status_reg  <= ST_ZERO_DEN;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= S_M0;
                        end
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1: if (mul_done) begin p0_reg <= mul_p; state_reg <= S_M2; end
                S_M2: if (mul_done) begin p1_reg <= mul_p; state_reg <= S_M3; end
                S_M3: if (mul_done) begin p2_reg <= mul_p; state_reg <= S_COMB; end
                S_COMB: begin
                    if (!mul_done) begin
                        // wait for an*bn
                    end else begin
                        state_reg <= S_GCD;
                        unique case (op_reg)
                            OP_ADD, OP_SUB: begin
                                num_reg <= sum_mag; den_reg <= p2_reg;
                                neg_reg <= (sum_mag != '0) && (sum_neg ^ (ad_neg_reg ^ bd_neg_reg));
                                gx_reg <= sum_mag; gy_reg <= p2_reg;
                            end
                            OP_MUL: begin
                                num_reg <= mul_p; den_reg <= p2_reg;
                                neg_reg <= (mul_p != '0) &&
                                    (an_neg_reg ^ bn_neg_reg ^ ad_neg_reg ^ bd_neg_reg);
                                gx_reg <= mul_p; gy_reg <= p2_reg;
                            end
                            OP_DIV: begin
                                num_reg <= p0_reg; den_reg <= p1_reg;
                                neg_reg <= (p0_reg != '0) &&
                                    (an_neg_reg ^ bd_neg_reg ^ ad_neg_reg ^ bn_neg_reg);
                                gx_reg <= p0_reg; gy_reg <= p1_reg;
                                if (p1_reg == '0) begin
                                    status_reg <= ST_ZERO_DEN;
                                    m_valid_reg <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                            end
                            OP_CMP: begin
                                order_reg <= cmp_ord;
                                m_valid_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            default: begin
                                num_reg <= DW'(an_reg); den_reg <= DW'(ad_reg);
                                neg_reg <= (an_reg != '0) && (an_neg_reg ^ ad_neg_reg);
                                gx_reg <= DW'(an_reg); gy_reg <= DW'(ad_reg);
                            end
                        endcase
                    end
                end
                S_GCD: begin
                    if (gy_reg == '0) begin
                        g_reg <= gx_reg;
                        state_reg <= S_DN;
                    end else begin
                        state_reg <= S_GCDW;
                    end
                end
                S_GCDW: if (div_sts.done) begin
                    gx_reg <= gy_reg;
                    gy_reg <= div_r;
                    state_reg <= S_GCD;
                end
                S_DN: state_reg <= S_DNW;
                S_DNW: if (div_sts.done) begin num_reg <= div_q; state_reg <= S_DD; end
                S_DD: state_reg <= S_DDW;
                S_DDW: if (div_sts.done) begin den_reg <= div_q; state_reg <= S_CHK; end
                S_CHK: begin
                    if (ovf) begin
                        status_reg <= ST_OVERFLOW;
                    end else begin
                        res_num_reg <= FIELD_BITS'($signed(n_out));
                        res_den_reg <= DEN_BITS'(den_reg);
                    end
                    m_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) begin
                    m_valid_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res_num = res_num_reg;
    assign m_res_den = res_den_reg;
    assign m_order   = order_reg;
    assign m_status  = status_reg;

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.start |-> !div_sts.busy) else $error("divider restarted while busy");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_res_num == '0 && m_res_den == '0))
        else $error("error result not zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule
`default_nettype wire
